// ===== sv/perspective_world_to_screen_macros.svh =====
// assertion macros for the projection pipeline
`ifndef PERSPECTIVE_WORLD_TO_SCREEN_MACROS_SVH
`define PERSPECTIVE_WORLD_TO_SCREEN_MACROS_SVH

`define PWS_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");

`define PWS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== sv/pws_pkg.sv =====
package pws_pkg;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned DIV_STEPS = 33;

  typedef enum logic [2:0] {
    REG_CAM_X = 3'd0,
    REG_CAM_Y = 3'd1,
    REG_CAM_Z = 3'd2,
    REG_ROW_A = 3'd3,
    REG_ROW_B = 3'd4,
    REG_ROW_C = 3'd5,
    REG_VIEW  = 3'd6,
    REG_KFOV  = 3'd7
  } reg_idx_t;

  localparam logic signed [24:0] SCR_MAX = 25'sd8388607;
  localparam logic signed [24:0] SCR_MIN = -25'sd8388608;
  localparam logic [32:0] Q_CAP = 33'h1_0000_0000;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } point_t;

  typedef struct packed {
    logic               visible;
    logic signed [23:0] screen_x;
    logic signed [23:0] screen_y;
    logic               clipped;
  } screen_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [63:0] data;
  } cfg_word_t;
endpackage

// ===== sv/pws_if.sv =====
interface pws_if #(
  parameter type payload_t = logic
) (
  input logic clk
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/pws_div.sv =====
module pws_div
  import pws_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [95:0] num,
  input  logic [63:0] den,
  output logic [32:0] quo
);
  // num < 2^96; quotient capped, so pre-check overflow on the top part
  logic [63:0] rem   [DIV_STEPS+1];
  logic [95:0] nsh   [DIV_STEPS+1];
  logic [63:0] dd    [DIV_STEPS+1];
  logic [32:0] q     [DIV_STEPS+1];
  logic        ovf   [DIV_STEPS+1];

  logic [64:0] top_w;

  always_comb begin
    top_w = {2'b00, num[95:33]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // top part is below den unless the quotient overflows
      rem[0] <= {1'b0, num[95:33]};
      nsh[0] <= num;
      dd[0]  <= den;
      q[0]   <= 33'd0;
      // quotient >= 2^33 when num >> 33 >= den; then capped
      ovf[0] <= top_w >= {1'b0, den};
    end
  end

  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
    logic [64:0] r_sh;
    logic [64:0] r_sub;
    always_comb begin
      r_sh  = {rem[s], nsh[s][32]};
      r_sub = r_sh - {1'b0, dd[s]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nsh[s+1] <= {nsh[s][94:0], 1'b0};
        dd[s+1]  <= dd[s];
        ovf[s+1] <= ovf[s];
        if (!r_sub[64]) begin
          rem[s+1] <= r_sub[63:0];
          q[s+1]   <= {q[s][31:0], 1'b1};
        end else begin
          rem[s+1] <= r_sh[63:0];
          q[s+1]   <= {q[s][31:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    if (ovf[DIV_STEPS] || q[DIV_STEPS] > Q_CAP) begin
      quo = Q_CAP;
    end else begin
      quo = q[DIV_STEPS];
    end
  end
endmodule

// ===== sv/perspective_world_to_screen.sv =====
// one point accepted per cycle while the pipeline is not stalled
// throughput: one word per cycle when not stalled, set by the 33-stage pipelined quotient unit
// stalls freeze the whole pipeline; the output buffer holds one word while blocked
// reset (rst, synchronous) clears valid bits and loads the identity camera,
// 1920x1080 viewport and the default field of view
module perspective_world_to_screen
  import pws_pkg::*;
(
  input logic  clk,
  input logic  rst,
  pws_if.sink   cfg,
  pws_if.sink   pin,
  pws_if.source pout
);
  `include "perspective_world_to_screen_macros.svh"

  localparam int unsigned PRE = 9;
  localparam int unsigned DEPTH = PRE + DIV_STEPS + 1;

  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [47:0] row_a, row_b, row_c;
  logic [31:0] vdims;
  logic [23:0] kfov;

  cfg_word_t cw;
  assign cw = cfg.data;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x <= '0;
      cam_y <= '0;
      cam_z <= '0;
      row_a <= 48'd16384;
      row_b <= 48'd1073741824;
      row_c <= 48'd70368744177664;
      vdims <= 32'd70780800;
      kfov  <= 24'd93595;
    end else if (cfg.valid && cw.index[3] == 1'b0) begin
      unique case (reg_idx_t'(cw.index[2:0]))
        REG_CAM_X: cam_x <= cw.data[31:0];
        REG_CAM_Y: cam_y <= cw.data[31:0];
        REG_CAM_Z: cam_z <= cw.data[31:0];
        REG_ROW_A: row_a <= cw.data[47:0];
        REG_ROW_B: row_b <= cw.data[47:0];
        REG_ROW_C: row_c <= cw.data[47:0];
        REG_VIEW:  vdims <= cw.data[31:0];
        REG_KFOV:  kfov  <= cw.data[23:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [DEPTH-1:0] vld;
  logic en;
  logic [1:0] sk_cnt;
  screen_t res;

  // advance only when the last stage is empty or its word can move on
  assign en = (sk_cnt == 2'd0) || (pout.ready && sk_cnt == 2'd1) || !vld[DEPTH-1];
  assign pin.ready = en;

  point_t pt;
  assign pt = pin.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[DEPTH-2:0], pin.valid};
    end
  end

  // s1: relative position
  logic signed [32:0] r0, r1, r2;
  // s2..s3: products then sums
  logic signed [48:0] p [3][3];
  logic signed [50:0] vx, vy, vz;
  // s4: magnitudes
  logic [49:0] mx, my, nz;
  logic sgx, sgy, vis4;
  logic [15:0] w4, h4;
  logic [23:0] k4;
  // s5: k*h
  logic [39:0] kh5;
  logic [49:0] mx5, my5, nz5;
  logic sgx5, sgy5, vis5;
  logic [15:0] w5, h5;
  // s6..s8: mag*kh split into 25x20 partials
  logic [44:0] px_lo, px_hi, py_lo, py_hi;
  logic [89:0] nx8, ny8;
  logic [63:0] d8;

  function automatic logic signed [15:0] ent(input logic [47:0] row, input int c);
    return row[16*c +: 16];
  endfunction

  logic [47:0] rows [3];
  assign rows[0] = row_a;
  assign rows[1] = row_b;
  assign rows[2] = row_c;

  always_ff @(posedge clk) begin
    if (en) begin
      r0 <= 33'(pt.world_x) - 33'(cam_x);
      r1 <= 33'(pt.world_y) - 33'(cam_y);
      r2 <= 33'(pt.world_z) - 33'(cam_z);
      for (int i = 0; i < 3; i++) begin
        p[i][0] <= r0 * ent(rows[i], 0);
        p[i][1] <= r1 * ent(rows[i], 1);
        p[i][2] <= r2 * ent(rows[i], 2);
      end
      vx <= 51'(p[0][0]) + 51'(p[0][1]) + 51'(p[0][2]);
      vy <= 51'(p[1][0]) + 51'(p[1][1]) + 51'(p[1][2]);
      vz <= 51'(p[2][0]) + 51'(p[2][1]) + 51'(p[2][2]);
      sgx  <= vx[50];
      sgy  <= vy[50];
      mx   <= vx[50] ? 50'(-vx) : 50'(vx);
      my   <= vy[50] ? 50'(-vy) : 50'(vy);
      nz   <= 50'(-vz);
      vis4 <= vz[50];
      w4   <= vdims[15:0];
      h4   <= vdims[31:16];
      k4   <= kfov;
      kh5  <= k4 * h4;
      mx5  <= mx;
      my5  <= my;
      nz5  <= nz;
      sgx5 <= sgx;
      sgy5 <= sgy;
      vis5 <= vis4;
      w5   <= w4;
      h5   <= h4;
      px_lo <= mx5[24:0] * kh5[19:0];
      px_hi <= mx5[49:25] * kh5[19:0];
      py_lo <= my5[24:0] * kh5[19:0];
      py_hi <= my5[49:25] * kh5[19:0];
    end
  end

  // second half of kh product
  logic [44:0] qx_lo, qx_hi, qy_lo, qy_hi;
  logic [44:0] px_lo7, px_hi7, py_lo7, py_hi7;
  logic [49:0] mx6, my6, nz6, nz7;
  logic [19:0] khh6;
  logic sgx6, sgy6, vis6, sgx7, sgy7, vis7;
  logic [15:0] w6, h6, w7, h7;

  always_ff @(posedge clk) begin
    if (en) begin
      mx6 <= mx5; my6 <= my5; nz6 <= nz5; khh6 <= kh5[39:20];
      sgx6 <= sgx5; sgy6 <= sgy5; vis6 <= vis5; w6 <= w5; h6 <= h5;
      px_lo7 <= px_lo; px_hi7 <= px_hi; py_lo7 <= py_lo; py_hi7 <= py_hi;
      qx_lo <= mx6[24:0] * khh6;
      qx_hi <= mx6[49:25] * khh6;
      qy_lo <= my6[24:0] * khh6;
      qy_hi <= my6[49:25] * khh6;
      nz7 <= nz6;
      sgx7 <= sgx6; sgy7 <= sgy6; vis7 <= vis6; w7 <= w6; h7 <= h6;
      nx8 <= 90'(px_lo7) + (90'(px_hi7) << 25) + (90'(qx_lo) << 20) + (90'(qx_hi) << 45);
      ny8 <= 90'(py_lo7) + (90'(py_hi7) << 25) + (90'(qy_lo) << 20) + (90'(qy_hi) << 45);
      d8  <= 64'(nz7) << 13;
    end
  end

  // side channel through divider stages
  logic sgx_d [DIV_STEPS+1];
  logic sgy_d [DIV_STEPS+1];
  logic vis_d [DIV_STEPS+1];
  logic [15:0] w_d [DIV_STEPS+1];
  logic [15:0] h_d [DIV_STEPS+1];
  logic sgx8, sgy8, vis8;
  logic [15:0] w8, h8;

  always_ff @(posedge clk) begin
    if (en) begin
      sgx8 <= sgx7; sgy8 <= sgy7; vis8 <= vis7; w8 <= w7; h8 <= h7;
      sgx_d[0] <= sgx8; sgy_d[0] <= sgy8; vis_d[0] <= vis8;
      w_d[0] <= w8; h_d[0] <= h8;
      for (int i = 1; i < DIV_STEPS + 1; i++) begin
        sgx_d[i] <= sgx_d[i-1]; sgy_d[i] <= sgy_d[i-1]; vis_d[i] <= vis_d[i-1];
        w_d[i] <= w_d[i-1]; h_d[i] <= h_d[i-1];
      end
    end
  end

  logic [32:0] qx, qy;
  pws_div u_divx (
    .clk(clk), .en(en), .num({6'd0, nx8}), .den(d8), .quo(qx));
  pws_div u_divy (
    .clk(clk), .en(en), .num({6'd0, ny8}), .den(d8), .quo(qy));

  // final: combine and saturate
  localparam int unsigned L = DIV_STEPS;
  logic signed [35:0] sx_w, sy_w;
  logic cx, cy;
  screen_t fin;

  always_comb begin
    sx_w = 36'(signed'({1'b0, w_d[L], 3'b000}));
    sx_w = sgx_d[L] ? sx_w - 36'(signed'({1'b0, qx})) : sx_w + 36'(signed'({1'b0, qx}));
    sy_w = 36'(signed'({1'b0, h_d[L], 3'b000}));
    sy_w = sgy_d[L] ? sy_w + 36'(signed'({1'b0, qy})) : sy_w - 36'(signed'({1'b0, qy}));
    cx = sx_w > 36'(SCR_MAX) || sx_w < 36'(SCR_MIN);
    cy = sy_w > 36'(SCR_MAX) || sy_w < 36'(SCR_MIN);
    fin.visible  = vis_d[L];
    fin.screen_x = sx_w > 36'(SCR_MAX) ? 24'h7FFFFF : (sx_w < 36'(SCR_MIN) ? 24'h800000 : sx_w[23:0]);
    fin.screen_y = sy_w > 36'(SCR_MAX) ? 24'h7FFFFF : (sy_w < 36'(SCR_MIN) ? 24'h800000 : sy_w[23:0]);
    fin.clipped  = cx || cy || h_d[L] == 16'd0;
    if (!vis_d[L]) begin
      fin = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= fin;
    end
  end

  // two-entry output skid buffer
  screen_t sk [2];
  logic push, pop;
  assign push = en && vld[DEPTH-1];
  assign pop  = pout.valid && pout.ready;
  assign pout.valid = sk_cnt != 2'd0;
  assign pout.data  = sk[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sk_cnt <= '0;
    end else begin
      sk_cnt <= sk_cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      sk[0] <= (sk_cnt == 2'd2) ? sk[1] : res;
      if (push) begin
        if (sk_cnt == 2'd2) sk[1] <= res;
      end
    end else if (push) begin
      if (sk_cnt == 2'd0) sk[0] <= res;
      else sk[1] <= res;
    end
  end

  `PWS_ASSERT_IMPL(a_skid_bound, clk, rst, 1'b1, sk_cnt != 2'd3)
  `PWS_ASSERT_IMPL(a_push_room, clk, rst, push && !pop, sk_cnt != 2'd2)
  `PWS_ASSERT_NEXT(a_hold_out, clk, rst, pout.valid && !pout.ready, pout.valid)
endmodule

// ===== dv/perspective_world_to_screen_test.sv =====
module perspective_world_to_screen_test
  import pws_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 44;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam logic [32:0] OFFSET_CAP = 33'h1_0000_0000;
  localparam longint SCREEN_HI = 8388607;
  localparam longint SCREEN_LO = -8388608;

  typedef struct {
    point_t  pt;
    bit      typed;
    screen_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  pws_if #(.payload_t(cfg_word_t)) cfg_if (clk);
  pws_if #(.payload_t(point_t))    pin_if (clk);
  pws_if #(.payload_t(screen_t))   pout_if (clk);

  perspective_world_to_screen dut (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_if),
    .pin  (pin_if),
    .pout (pout_if)
  );

  // predictor copy of the camera registers
  logic [31:0] cam_x, cam_y, cam_z;
  logic [47:0] rot_row [3];
  logic [31:0] view_dims;
  logic [23:0] kfov;

  screen_t screens_due[$];
  int      fails;
  int      points_sent;
  int      screens_seen;
  int      cfg_writes;
  longint  cycles = 0;
  bit      calm;
  int      sink_hold;
  int      sink_gap;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [32:0] offset_term(logic [63:0] mag, logic [63:0] kh,
                                             logic [63:0] dz);
    logic [127:0] num;
    logic [127:0] q;
    num = {64'd0, mag} * {64'd0, kh};
    q = num / {64'd0, dz};
    if (q > {95'd0, OFFSET_CAP}) q = {95'd0, OFFSET_CAP};
    return q[32:0];
  endfunction

  function automatic screen_t project(point_t p);
    longint      rel [3];
    longint      v [3];
    logic [63:0] kh, dz, mx, my;
    logic [15:0] w, h;
    longint      sx, sy, qx, qy;
    bit          clip;
    screen_t     s;
    rel[0] = longint'(p.world_x) - longint'($signed(cam_x));
    rel[1] = longint'(p.world_y) - longint'($signed(cam_y));
    rel[2] = longint'(p.world_z) - longint'($signed(cam_z));
    for (int r = 0; r < 3; r++) begin
      v[r] = 0;
      for (int c = 0; c < 3; c++)
        v[r] += rel[c] * longint'($signed(rot_row[r][16*c +: 16]));
    end
    s = '0;
    if (v[2] >= 0) return s;
    w = view_dims[15:0];
    h = view_dims[31:16];
    kh = 64'(kfov) * 64'(h);
    dz = 64'(-v[2]) << 13;
    mx = v[0] < 0 ? 64'(-v[0]) : 64'(v[0]);
    my = v[1] < 0 ? 64'(-v[1]) : 64'(v[1]);
    qx = longint'(offset_term(mx, kh, dz));
    qy = longint'(offset_term(my, kh, dz));
    sx = longint'(w) * 8 + (v[0] < 0 ? -qx : qx);
    sy = longint'(h) * 8 - (v[1] < 0 ? -qy : qy);
    clip = 1'b0;
    if (sx > SCREEN_HI) begin sx = SCREEN_HI; clip = 1'b1; end
    if (sx < SCREEN_LO) begin sx = SCREEN_LO; clip = 1'b1; end
    if (sy > SCREEN_HI) begin sy = SCREEN_HI; clip = 1'b1; end
    if (sy < SCREEN_LO) begin sy = SCREEN_LO; clip = 1'b1; end
    if (h == 16'd0) clip = 1'b1;
    s.visible  = 1'b1;
    s.screen_x = sx[23:0];
    s.screen_y = sy[23:0];
    s.clipped  = clip;
    return s;
  endfunction

  function automatic void load_defaults();
    cam_x = '0;
    cam_y = '0;
    cam_z = '0;
    rot_row[0] = 48'd16384;
    rot_row[1] = 48'd1073741824;
    rot_row[2] = 48'd70368744177664;
    view_dims = 32'd70780800;
    kfov = 24'd93595;
  endfunction

  // output side: random back-pressure
  always @(posedge clk) begin
    if (rst) begin
      pout_if.ready <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      pout_if.ready <= 1'b0;
    end else begin
      sink_gap = pick_gap();
      pout_if.ready <= (sink_gap == 0);
      sink_hold <= sink_gap > 0 ? sink_gap - 1 : 0;
    end
  end

  always @(posedge clk) begin
    if (!rst && pout_if.valid && pout_if.ready) begin
      screens_seen++;
      if (screens_due.size() == 0) begin
        $error("unexpected word %h", pout_if.data);
        fails++;
      end else begin
        screen_t e;
        e = screens_due.pop_front();
        if (pout_if.data.visible !== e.visible) begin
          $error("visible expected %0d actual %0d", e.visible, pout_if.data.visible);
          fails++;
        end
        if (pout_if.data.screen_x !== e.screen_x) begin
          $error("screen_x expected %0d actual %0d", e.screen_x, pout_if.data.screen_x);
          fails++;
        end
        if (pout_if.data.screen_y !== e.screen_y) begin
          $error("screen_y expected %0d actual %0d", e.screen_y, pout_if.data.screen_y);
          fails++;
        end
        if (pout_if.data.clipped !== e.clipped) begin
          $error("clipped expected %0d actual %0d", e.clipped, pout_if.data.clipped);
          fails++;
        end
      end
    end
  end

  task automatic drain();
    while (screens_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 16) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [63:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= '{index: idx, data: val};
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cfg_writes++;
    case (idx)
      4'(REG_CAM_X): cam_x = val[31:0];
      4'(REG_CAM_Y): cam_y = val[31:0];
      4'(REG_CAM_Z): cam_z = val[31:0];
      4'(REG_ROW_A): rot_row[0] = val[47:0];
      4'(REG_ROW_B): rot_row[1] = val[47:0];
      4'(REG_ROW_C): rot_row[2] = val[47:0];
      4'(REG_VIEW):  view_dims = val[31:0];
      4'(REG_KFOV):  kfov = val[23:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // sends one word; valid stays high across back-to-back words
  task automatic send_point(point_t p, bit typed, screen_t want);
    int g;
    g = pick_gap();
    if (g > 0) begin
      pin_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pin_if.valid <= 1'b1;
    pin_if.data <= p;
    do @(posedge clk); while (!pin_if.ready);
    screens_due.push_back(typed ? want : project(p));
    points_sent++;
  endtask

  task automatic idle_input();
    pin_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic point_t rand_point();
    point_t p;
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      p.world_x = $signed(cam_x) + ($urandom_range(0, 1 << 21) - (1 << 20));
      p.world_y = $signed(cam_y) + ($urandom_range(0, 1 << 21) - (1 << 20));
      p.world_z = $signed(cam_z) - $urandom_range(0, 1 << 20) + $urandom_range(0, 1 << 16);
    end else begin
      p.world_x = $urandom;
      p.world_y = $urandom;
      p.world_z = $urandom;
    end
    return p;
  endfunction

  function automatic logic [47:0] rand_row();
    logic [47:0] row;
    for (int c = 0; c < 3; c++)
      row[16*c +: 16] = $urandom_range(0, 3) == 0 ? 16'($urandom) :
                        16'($urandom_range(0, 32768) - 16384);
    return row;
  endfunction

  function automatic point_t mk(int x, int y, int z);
    point_t p;
    p.world_x = x;
    p.world_y = y;
    p.world_z = z;
    return p;
  endfunction

  stim_row_t directed [$];
  logic [63:0] regs [8];

  initial begin
    rst = 1'b1;
    fails = 0;
    points_sent = 0;
    screens_seen = 0;
    cfg_writes = 0;
    calm = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    pin_if.valid = 1'b0;
    pin_if.data = '0;
    load_defaults();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default camera: identity, 1920x1080
    directed.push_back('{mk(0, 0, 0), 1'b1, '{1'b0, 24'sd0, 24'sd0, 1'b0}});
    directed.push_back('{mk(0, 0, 256), 1'b1, '{1'b0, 24'sd0, 24'sd0, 1'b0}});
    directed.push_back('{mk(32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1'b1,
                         '{1'b0, 24'sd0, 24'sd0, 1'b0}});
    directed.push_back('{mk(0, 0, -256), 1'b1, '{1'b1, 24'sd15360, 24'sd8640, 1'b0}});
    directed.push_back('{mk(0, 0, 32'h80000000), 1'b1,
                         '{1'b1, 24'sd15360, 24'sd8640, 1'b0}});
    directed.push_back('{mk(256, 256, -256), 1'b0, '0});
    directed.push_back('{mk(-256, -256, -256), 1'b0, '0});
    directed.push_back('{mk(32'h7fffffff, 0, -1), 1'b0, '0});
    directed.push_back('{mk(32'h80000000, 0, -1), 1'b0, '0});
    directed.push_back('{mk(0, 32'h7fffffff, -1), 1'b0, '0});
    directed.push_back('{mk(0, 32'h80000000, -1), 1'b0, '0});
    directed.push_back('{mk(32'h7fffffff, 32'h80000000, 32'h80000000), 1'b0, '0});
    directed.push_back('{mk(32'h80000000, 32'h7fffffff, 32'h80000000), 1'b0, '0});
    directed.push_back('{mk(-1, -1, -1), 1'b0, '0});
    directed.push_back('{mk(1000, -2000, -3000), 1'b0, '0});
    directed.push_back('{mk(512, 0, 0), 1'b0, '0});
    foreach (directed[i]) send_point(directed[i].pt, directed[i].typed, directed[i].want);
    idle_input();
    drain();

    for (int ph = 0; ph < 9; ph++) begin
      regs[REG_CAM_X] = 64'($urandom_range(0, 1 << 20) - (1 << 19));
      regs[REG_CAM_Y] = 64'($urandom_range(0, 1 << 20) - (1 << 19));
      regs[REG_CAM_Z] = 64'($urandom_range(0, 1 << 20) - (1 << 19));
      regs[REG_ROW_A] = ph == 0 ? 64'd16384 : 64'(rand_row());
      regs[REG_ROW_B] = ph == 0 ? 64'd1073741824 : 64'(rand_row());
      regs[REG_ROW_C] = ph == 0 ? 64'd70368744177664 : 64'(rand_row());
      regs[REG_VIEW]  = {32'($urandom) , 16'($urandom_range(0, 4096)),
                         16'($urandom_range(0, 4096))};
      regs[REG_KFOV]  = 64'($urandom_range(1 << 14, 1 << 18));
      case (ph)
        1: regs[REG_VIEW][15:0] = 16'd0;
        2: regs[REG_VIEW][31:16] = 16'd0;
        3: begin
          regs[REG_VIEW] = 64'hffff_ffff;
          regs[REG_KFOV] = 64'hff_ffff;
        end
        4: regs[REG_KFOV] = 64'd0;
        5: begin
          regs[REG_CAM_X] = 64'h7fff_ffff;
          regs[REG_CAM_Y] = 64'h8000_0000;
          regs[REG_CAM_Z] = 64'h7fff_ffff;
        end
        6: begin
          regs[REG_CAM_X] = 64'h8000_0000;
          regs[REG_CAM_Y] = 64'h7fff_ffff;
          regs[REG_CAM_Z] = 64'h8000_0000;
          regs[REG_ROW_A] = 64'h8000_8000_8000;
          regs[REG_ROW_C] = 64'h7fff_7fff_7fff;
        end
        default: ;
      endcase
      for (int i = 0; i < 8; i++) write_reg(4'(i), $urandom_range(0, 1) ? regs[i] :
                                            {32'($urandom), regs[i][31:0]} | regs[i]);
      if (ph == 2) write_reg(4'(NUM_REGS) + 4'($urandom_range(0, 7)), 64'hdead_beef);
      calm = (ph % 3 == 1);
      for (int n = 0; n < 55; n++) begin
        if (ph == 4 && n == 25) begin
          idle_input();
          while (screens_due.size() != 0) @(posedge clk);
        end
        send_point(rand_point(), 1'b0, '0);
      end
      idle_input();
      drain();
    end

    $display("sent %0d points over 10 camera settings with %0d register writes",
             points_sent, cfg_writes);
    $display("checked %0d screen words, %0d mismatches", screens_seen, fails);
    if (fails == 0 && screens_due.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
